FILE: hdl/ihq_pkg.sv
`timescale 1ns / 1ps
package ihq_pkg;
    localparam int CAPACITY   = 1024;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int VERTEX_W   = 10;
    localparam int VERTEX_N   = 1 << VERTEX_W;
    localparam int DIST_W     = 16;
    localparam int COUNT_W    = SLOT_W + 1;
    localparam logic [DIST_W-1:0] START_DIST = DIST_W'(9999);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DECR   = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [DIST_W-1:0]   distance;
    } entry_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] out_vertex;
        logic [DIST_W-1:0]   out_distance;
        status_t             status;
        logic                present;
        logic [COUNT_W-1:0]  entry_count;
    } result_t;
endpackage

FILE: hdl/ihq_ram.sv
`timescale 1ns / 1ps
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/ihq_engine.sv
`timescale 1ns / 1ps
module ihq_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  ihq_pkg::op_t                  op,
    input  logic [ihq_pkg::VERTEX_W-1:0]  vertex,
    input  logic [ihq_pkg::DIST_W-1:0]    new_distance,
    input  logic                          res_free,
    output logic                          idle,
    output logic                          done,
    output ihq_pkg::result_t              res
);
    import ihq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_MAP_RD  = 11'b00000000010,
        S_SLOT_RD = 11'b00000000100,
        S_POP_RD0 = 11'b00000001000,
        S_POP_RD1 = 11'b00000010000,
        S_RISE    = 11'b00000100000,
        S_RISE_RD = 11'b00001000000,
        S_SINK    = 11'b00010000000,
        S_SINK_L  = 11'b00100000000,
        S_SINK_R  = 11'b01000000000,
        S_CLEAR   = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic                fin_reg, fin_next;
    op_t                 op_reg, op_next;
    logic [VERTEX_W-1:0] v_reg, v_next;
    logic [DIST_W-1:0]   nd_reg, nd_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    entry_t              cur_reg, cur_next;
    entry_t              left_reg, left_next;
    logic [COUNT_W-1:0]  fill_reg, fill_next;
    result_t             res_reg, res_next;
    logic [VERTEX_W-1:0] clr_reg, clr_next;

    logic                heap_we, map_we;
    logic [SLOT_W-1:0]   heap_waddr, heap_raddr, map_wdata, map_q;
    entry_t              heap_wdata, heap_q;
    logic [VERTEX_W-1:0] map_waddr, map_raddr;

    logic                present;
    logic [SLOT_W-1:0]   parent;
    logic [COUNT_W-1:0]  left_idx, right_idx;
    logic                take_left, take_right;

    ihq_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_heap (
        .aclk, .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_q)
    );

    ihq_ram #(.WIDTH(SLOT_W), .DEPTH(VERTEX_N)) u_map (
        .aclk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_q)
    );

    assign present   = ({1'b0, idx_reg} < fill_reg) && (heap_q.vertex == v_reg);
    assign parent    = SLOT_W'((idx_reg - SLOT_W'(1)) >> 1);
    assign left_idx  = {idx_reg, 1'b1};
    assign right_idx = left_idx + COUNT_W'(1);
    assign take_left = left_reg.distance < cur_reg.distance;
    assign take_right = take_left ? (heap_q.distance < left_reg.distance)
                                  : (heap_q.distance < cur_reg.distance);

    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        op_next    = op_reg;
        v_next     = v_reg;
        nd_next    = nd_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        left_next  = left_reg;
        fill_next  = fill_reg;
        res_next   = res_reg;
        clr_next   = clr_reg;
        heap_we    = 1'b0;
        heap_waddr = idx_reg;
        heap_wdata = cur_reg;
        heap_raddr = '0;
        map_we     = 1'b0;
        map_waddr  = cur_reg.vertex;
        map_wdata  = idx_reg;
        map_raddr  = vertex;

        if (fin_reg) begin
            if (res_free) begin
                fin_next = 1'b0;
            end
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    map_we    = 1'b1;
                    map_waddr = clr_reg;
                    map_wdata = '0;
                    clr_next  = clr_reg + VERTEX_W'(1);
                    if (clr_reg == '1) begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        op_next  = op;
                        v_next   = vertex;
                        nd_next  = new_distance;
                        res_next = '{out_vertex: vertex, out_distance: '0,
                                     status: ST_OK, present: 1'b0,
                                     entry_count: fill_reg};
                        if (op == OP_POP) begin
                            if (fill_reg == '0) begin
                                res_next.status = ST_EMPTY;
                                fin_next = 1'b1;
                            end else begin
                                state_next = S_POP_RD0;
                            end
                        end else begin
                            state_next = S_MAP_RD;
                        end
                    end
                end
                S_MAP_RD: begin
                    heap_raddr = map_q;
                    idx_next   = map_q;
                    state_next = S_SLOT_RD;
                end
                S_SLOT_RD: begin
                    unique case (op_reg)
                        OP_INSERT: begin
                            if (fill_reg == COUNT_W'(CAPACITY) || present) begin
                                res_next.status = ST_FULL;
                                state_next = S_IDLE;
                                fin_next   = 1'b1;
                            end else begin
                                idx_next   = fill_reg[SLOT_W-1:0];
                                cur_next   = '{vertex: v_reg, distance: START_DIST};
                                fill_next  = fill_reg + COUNT_W'(1);
                                state_next = S_RISE;
                            end
                        end
                        OP_DECR: begin
                            if (!present) begin
                                res_next.status = ST_ABSENT;
                                state_next = S_IDLE;
                                fin_next   = 1'b1;
                            end else begin
                                cur_next   = '{vertex: v_reg, distance: nd_reg};
                                state_next = (nd_reg < heap_q.distance) ? S_RISE : S_SINK;
                            end
                        end
                        default: begin
                            res_next.present = present;
                            state_next = S_IDLE;
                            fin_next   = 1'b1;
                        end
                    endcase
                end
                S_POP_RD0: begin
                    res_next.out_vertex   = heap_q.vertex;
                    res_next.out_distance = heap_q.distance;
                    fill_next  = fill_reg - COUNT_W'(1);
                    heap_raddr = fill_next[SLOT_W-1:0];
                    state_next = S_POP_RD1;
                end
                S_POP_RD1: begin
                    cur_next = heap_q;
                    idx_next = '0;
                    if (fill_reg == '0) begin
                        state_next = S_IDLE;
                        fin_next   = 1'b1;
                    end else begin
                        state_next = S_SINK;
                    end
                end
                S_RISE: begin
                    if (idx_reg == '0) begin
                        heap_we    = 1'b1;
                        map_we     = 1'b1;
                        state_next = S_IDLE;
                        fin_next   = 1'b1;
                    end else begin
                        heap_raddr = parent;
                        state_next = S_RISE_RD;
                    end
                end
                S_RISE_RD: begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                    if (cur_reg.distance < heap_q.distance) begin
                        heap_wdata = heap_q;
                        map_waddr  = heap_q.vertex;
                        idx_next   = parent;
                        state_next = S_RISE;
                    end else begin
                        state_next = S_IDLE;
                        fin_next   = 1'b1;
                    end
                end
                S_SINK: begin
                    if (left_idx >= fill_reg) begin
                        heap_we    = 1'b1;
                        map_we     = 1'b1;
                        state_next = S_IDLE;
                        fin_next   = 1'b1;
                    end else begin
                        heap_raddr = left_idx[SLOT_W-1:0];
                        state_next = S_SINK_L;
                    end
                end
                S_SINK_L: begin
                    left_next = heap_q;
                    if (right_idx < fill_reg) begin
                        heap_raddr = right_idx[SLOT_W-1:0];
                        state_next = S_SINK_R;
                    end else begin
                        heap_we = 1'b1;
                        map_we  = 1'b1;
                        if (heap_q.distance < cur_reg.distance) begin
                            heap_wdata = heap_q;
                            map_waddr  = heap_q.vertex;
                            idx_next   = left_idx[SLOT_W-1:0];
                            state_next = S_SINK;
                        end else begin
                            state_next = S_IDLE;
                            fin_next   = 1'b1;
                        end
                    end
                end
                S_SINK_R: begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                    if (take_right) begin
                        heap_wdata = heap_q;
                        map_waddr  = heap_q.vertex;
                        idx_next   = right_idx[SLOT_W-1:0];
                        state_next = S_SINK;
                    end else if (take_left) begin
                        heap_wdata = left_reg;
                        map_waddr  = left_reg.vertex;
                        idx_next   = left_idx[SLOT_W-1:0];
                        state_next = S_SINK;
                    end else begin
                        state_next = S_IDLE;
                        fin_next   = 1'b1;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
        if (fin_next && !fin_reg) begin
            res_next.entry_count = fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            fin_reg   <= 1'b0;
            fill_reg  <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            fill_reg  <= fill_next;
            clr_reg   <= clr_next;
        end
        op_reg   <= op_next;
        v_reg    <= v_next;
        nd_reg   <= nd_next;
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        left_reg <= left_next;
        res_reg  <= res_next;
    end

    assign idle = (state_reg == S_IDLE) && !fin_reg;
    assign done = fin_reg && res_free;
    assign res  = res_reg;
endmodule

FILE: hdl/indexed_min_heap_queue.sv
`timescale 1ns / 1ps
// channel   ports                                     direction
// request   s_valid s_ready s_op s_vertex s_new_distance   in
// result    m_valid m_ready m_out_vertex m_out_distance
//           m_status m_present m_entry_count              out
// one request at a time; a request does its lookup reads (map and slot, or for a
// pop root and last slot; none for a pop on an empty queue), then any sift, then
// hands over its result; sift up reads each parent, sift down the left then
// the right child, up to 10 levels, set by the single read port of the heap memory
// after reset a clearing pass writes all 1024 position map slots, then s_ready rises
// a stalled result holds in the output register; the next request may then enter
module indexed_min_heap_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [ihq_pkg::VERTEX_W-1:0]  s_vertex,
    input  logic [ihq_pkg::DIST_W-1:0]    s_new_distance,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ihq_pkg::VERTEX_W-1:0]  m_out_vertex,
    output logic [ihq_pkg::DIST_W-1:0]    m_out_distance,
    output logic [1:0]                    m_status,
    output logic                          m_present,
    output logic [ihq_pkg::COUNT_W-1:0]   m_entry_count
);
    import ihq_pkg::*;

    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;
    logic    eng_idle, eng_done, res_free;
    result_t eng_res;

    assign res_free = !m_valid_reg || m_ready;
    assign s_ready  = eng_idle;

    ihq_engine u_engine (
        .aclk, .aresetn,
        .start(s_valid && eng_idle),
        .op(op_t'(s_op)),
        .vertex(s_vertex),
        .new_distance(s_new_distance),
        .res_free,
        .idle(eng_idle),
        .done(eng_done),
        .res(eng_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (eng_done) begin
            m_valid_next = 1'b1;
            out_next     = eng_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_vertex   = out_reg.out_vertex;
    assign m_out_distance = out_reg.out_distance;
    assign m_status       = out_reg.status;
    assign m_present      = out_reg.present;
    assign m_entry_count  = out_reg.entry_count;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= COUNT_W'(CAPACITY)) else $error("count overflow");
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_entry_count == '0) else $error("empty status");
    a_present_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_present |-> m_status == ST_OK) else $error("present with error");
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("accept while busy");
endmodule
